### rtl/arpm_pkg.sv
// arpm_pkg: shared types and constants of the arp request matcher
// no dependencies; used by the byte and config interfaces, the field checker and the top level

package arpm_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned MAC_W      = 48;
    localparam int unsigned IP_W       = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;

    // byte offsets inside the frame
    localparam logic [POS_W-1:0] POS_HDR_FIRST = 6'd12;
    localparam logic [POS_W-1:0] POS_MAC_FIRST = 6'd22;
    localparam logic [POS_W-1:0] POS_MAC_LAST  = 6'd27;
    localparam logic [POS_W-1:0] POS_SIP_FIRST = 6'd28;
    localparam logic [POS_W-1:0] POS_SIP_LAST  = 6'd31;
    localparam logic [POS_W-1:0] POS_TIP_FIRST = 6'd38;
    localparam logic [POS_W-1:0] POS_TIP_LAST  = 6'd41;
    localparam logic [POS_W-1:0] FRAME_MIN     = 6'd42;

    localparam logic [BYTE_W-1:0] MAC_BYTES = 8'd6;
    localparam logic [BYTE_W-1:0] IP_BYTES  = 8'd4;

    // fixed arp header: ethertype, htype, ptype, hlen, plen, opcode
    localparam int unsigned HDR_LEN = 10;
    localparam logic [BYTE_W-1:0] HDR_BYTES [HDR_LEN] = '{
        8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00,
        MAC_BYTES, IP_BYTES, 8'h00, 8'h01
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_HW    = 2'd0,
        REG_SRC_PROTO = 2'd1,
        REG_DST_PROTO = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [MAC_W-1:0] src_hw_addr;
        logic [IP_W-1:0]  src_proto_addr;
        logic [IP_W-1:0]  dst_proto_addr;
    } match_cfg_t;

    typedef struct packed {
        logic checked;
        logic differs;
    } check_t;

endpackage

### rtl/arpm_byte_if.sv
// arpm_byte_if: valid/ready channel carrying one frame byte per word
// depends on arpm_pkg

interface arpm_byte_if;
    logic                           valid;
    logic                           ready;
    logic [arpm_pkg::BYTE_W-1:0]    frame_byte;
    logic                           last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

### rtl/arpm_result_if.sv
// arpm_result_if: valid/ready channel carrying one match verdict per word
// no dependencies

interface arpm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

### rtl/arpm_cfg_if.sv
// arpm_cfg_if: register write channel, index plus data per word
// depends on arpm_pkg

interface arpm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [arpm_pkg::CFG_IDX_W-1:0]    index;
    logic [arpm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/arpm_field_check.sv
// arpm_field_check: compares one frame byte with the value expected at its offset
// depends on arpm_pkg

module arpm_field_check (
    input  logic [arpm_pkg::POS_W-1:0]  pos,
    input  logic [arpm_pkg::BYTE_W-1:0] frame_byte,
    input  arpm_pkg::match_cfg_t        cfg,
    output arpm_pkg::check_t            result
);

    logic [3:0]                  hdr_idx;
    logic [2:0]                  mac_idx;
    logic [1:0]                  sip_idx;
    logic [1:0]                  tip_idx;
    logic [arpm_pkg::BYTE_W-1:0] want;

    // byte index counted from the least significant end of each address
    assign hdr_idx = 4'(pos - arpm_pkg::POS_HDR_FIRST);
    assign mac_idx = 3'(arpm_pkg::POS_MAC_LAST - pos);
    assign sip_idx = 2'(arpm_pkg::POS_SIP_LAST - pos);
    assign tip_idx = 2'(arpm_pkg::POS_TIP_LAST - pos);

    always_comb
    begin
        want           = '0;
        result.checked = 1'b0;
        priority if (pos >= arpm_pkg::POS_TIP_FIRST && pos <= arpm_pkg::POS_TIP_LAST)
        begin
            want           = cfg.dst_proto_addr[{tip_idx, 3'b000} +: 8];
            result.checked = 1'b1;
        end
        else if (pos >= arpm_pkg::POS_SIP_FIRST && pos <= arpm_pkg::POS_SIP_LAST)
        begin
            want           = cfg.src_proto_addr[{sip_idx, 3'b000} +: 8];
            result.checked = 1'b1;
        end
        else if (pos >= arpm_pkg::POS_MAC_FIRST && pos <= arpm_pkg::POS_MAC_LAST)
        begin
            want           = cfg.src_hw_addr[{mac_idx, 3'b000} +: 8];
            result.checked = 1'b1;
        end
        else if (pos >= arpm_pkg::POS_HDR_FIRST && pos < arpm_pkg::POS_MAC_FIRST)
        begin
            want           = arpm_pkg::HDR_BYTES[hdr_idx];
            result.checked = 1'b1;
        end
        else
        begin
            want           = '0;
            result.checked = 1'b0;
        end
        result.differs = result.checked && (want != frame_byte);
    end

endmodule

### rtl/arp_request_matcher_top.sv
// arp_request_matcher_top: filters ethernet frames for one expected arp request
// depends on arpm_pkg, the three channel interfaces and arpm_field_check
// a verdict word is registered in the result slot once the last frame byte leaves the input stage
// throughput: one frame byte per cycle, back to back, set by the input stage
// a byte is taken even while a verdict waits; only a last byte stalls on it
// reset: rst_n clears the pipeline valids, byte position, mismatch flag and registers

module arp_request_matcher_top (
    input  logic          clk,
    input  logic          rst_n,
    arpm_byte_if.sink     frame_in,
    arpm_result_if.source result_out,
    arpm_cfg_if.sink      cfg
);

    // configuration registers
    arpm_pkg::match_cfg_t cfg_reg;

    // input stage
    logic                        in_valid_reg;
    logic [arpm_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;

    // per-frame state
    logic [arpm_pkg::POS_W-1:0]  pos_reg;
    logic [arpm_pkg::POS_W-1:0]  pos_next;
    logic                        mismatch_reg;
    logic                        mismatch_next;

    // result stage
    logic                        out_valid_reg;
    logic                        out_matched_reg;

    logic                        stage_go;
    logic                        frame_end;
    logic                        in_take;
    logic                        in_window;
    arpm_pkg::check_t            check;

    // config writes are taken at any time, unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                arpm_pkg::REG_SRC_HW:
                begin
                    cfg_reg.src_hw_addr <= cfg.data;
                end
                arpm_pkg::REG_SRC_PROTO:
                begin
                    cfg_reg.src_proto_addr <= cfg.data[arpm_pkg::IP_W-1:0];
                end
                arpm_pkg::REG_DST_PROTO:
                begin
                    cfg_reg.dst_proto_addr <= cfg.data[arpm_pkg::IP_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // a middle byte always drains; a last byte needs a free result slot
    assign stage_go  = in_valid_reg &&
                       (!in_last_reg || !out_valid_reg || result_out.ready);
    assign frame_end = stage_go && in_last_reg;
    assign in_take   = frame_in.valid && frame_in.ready;

    assign frame_in.ready = !in_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_in.ready)
        begin
            in_valid_reg <= frame_in.valid;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= frame_in.frame_byte;
            in_last_reg <= frame_in.last_byte;
        end
    end

    // offset compare for the byte in the input stage
    arpm_field_check u_check (
        .pos        (pos_reg),
        .frame_byte (in_byte_reg),
        .cfg        (cfg_reg),
        .result     (check)
    );

    // position saturates at the minimum arp frame length
    assign in_window     = pos_reg < arpm_pkg::FRAME_MIN;
    assign pos_next      = in_window ? pos_reg + 6'd1 : pos_reg;
    assign mismatch_next = mismatch_reg || (in_window && check.differs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (frame_end)
        begin
            pos_reg      <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
        end
    end

    // result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            out_matched_reg <= !mismatch_next && (pos_next >= arpm_pkg::FRAME_MIN);
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.matched = out_matched_reg;

    // position never runs past the saturation point
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= arpm_pkg::FRAME_MIN)
        else $error("byte position beyond saturation");

    // a finished frame always lands a verdict in the result slot
    a_frame_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> result_out.valid)
        else $error("frame end without verdict");

    // per-frame state starts clean after a last byte
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (pos_reg == '0) && !mismatch_reg)
        else $error("frame state not cleared");

    // a short frame is never reported as a match
    a_short_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end && (pos_next < arpm_pkg::FRAME_MIN) |=> !result_out.matched)
        else $error("short frame matched");

endmodule
